### rtl/length_prefixed_frame_filter_top_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the length-prefixed frame filter
// Implication checks on the clock and reset of the module that uses them.
// ----------------------------------------------------------------------------
`ifndef LENGTH_PREFIXED_FRAME_FILTER_TOP_ASSERT_SVH
`define LENGTH_PREFIXED_FRAME_FILTER_TOP_ASSERT_SVH

// Same-cycle implication
`define LPFF_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication
`define LPFF_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/lpff_pkg.sv
// ----------------------------------------------------------------------------
// lpff_pkg
// Shared types and constants of the length-prefixed frame filter.
// ----------------------------------------------------------------------------
package lpff_pkg;

    // Configuration register indexes
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] REG_INTERCEPT    = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SUMMARY_TYPE = 1'd1;

    // Result kinds
    localparam logic [2:0] KIND_FWD       = 3'd0;
    localparam logic [2:0] KIND_OK        = 3'd1;
    localparam logic [2:0] KIND_BAD_CRC   = 3'd2;
    localparam logic [2:0] KIND_BAD_SIZE  = 3'd3;
    localparam logic [2:0] KIND_EMPTY     = 3'd4;
    localparam logic [2:0] KIND_DUPLICATE = 3'd5;

    // FNV-1a 32-bit
    localparam logic [31:0] FNV_BASIS = 32'h811C_9DC5;
    localparam logic [31:0] FNV_PRIME = 32'd16777619;

    // Summary layout: type byte + 21 payload bytes
    localparam logic [15:0] SUMMARY_FRAME_LEN = 16'd22;
    localparam logic [15:0] SUMMARY_PAYLOAD   = 16'd21;

    // Request from the parser to the output side
    typedef struct packed {
        logic [2:0]  kind;
        logic        triple;      // three bytes to forward (b0, b1, b2)
        logic [7:0]  b0;
        logic [7:0]  b1;
        logic [7:0]  b2;
        logic [7:0]  won_flag;
        logic [31:0] own_score;
        logic [31:0] own_lines;
        logic [31:0] peer_score;
        logic [31:0] peer_lines;
        logic [31:0] duration_sec;
    } cmd_t;

    // One result item
    typedef struct packed {
        logic [2:0]  kind;
        logic [7:0]  out_byte;
        logic        last;
        logic [7:0]  won_flag;
        logic [31:0] own_score;
        logic [31:0] own_lines;
        logic [31:0] peer_score;
        logic [31:0] peer_lines;
        logic [31:0] duration_sec;
    } res_t;

endpackage

### rtl/lpff_front.sv
// ----------------------------------------------------------------------------
// lpff_front
// Frame parser: accepts stream bytes, tracks the frame, hashes and decodes
// summaries, and issues one request per byte that causes results.
// ----------------------------------------------------------------------------
`include "length_prefixed_frame_filter_top_assert.svh"

module lpff_front
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic [7:0]                     in_byte,
    input  logic                           cfg_we,
    input  logic [lpff_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [7:0]                     cfg_data,
    input  logic                           q_full,
    output logic                           push,
    output lpff_pkg::cmd_t                 push_cmd
);

    localparam logic [2:0] PH_LEN_LO  = 3'd0;
    localparam logic [2:0] PH_LEN_HI  = 3'd1;
    localparam logic [2:0] PH_TYPE    = 3'd2;
    localparam logic [2:0] PH_PAYLOAD = 3'd3;
    localparam logic [2:0] PH_CHECK   = 3'd4;

    logic             intercept_reg, intercept_next;
    logic [7:0]       sum_type_reg, sum_type_next;
    logic [2:0]       phase_reg, phase_next;
    logic [15:0]      frame_len_reg, frame_len_next;
    logic [15:0]      byte_count_reg, byte_count_next;
    logic             is_summary_reg, is_summary_next;
    logic [31:0]      hash_reg, hash_next;
    logic [31:0]      rx_crc_reg, rx_crc_next;
    logic [7:0]       won_reg, won_next;
    logic [4:0][31:0] words_reg, words_next;
    logic             captured_reg, captured_next;

    logic             accept;
    logic [31:0]      hash_step;
    logic [15:0]      bc_inc;
    logic [15:0]      len_full;
    logic [4:0]       pos;
    logic [31:0]      rx_new;
    logic [31:0]      calc;
    logic [31:0]      lane_byte;

    // Hold off the input while a register write is taken
    assign in_ready  = !q_full && !cfg_we;
    assign accept    = in_valid && in_ready;
    assign hash_step = (hash_reg ^ {24'h0, in_byte}) * lpff_pkg::FNV_PRIME;
    assign bc_inc    = byte_count_reg + 16'd1;
    assign len_full  = {in_byte, frame_len_reg[7:0]};
    assign pos       = byte_count_reg[4:0] - 5'd1;
    assign lane_byte = {24'h0, in_byte};
    assign rx_new    = rx_crc_reg | (lane_byte << {byte_count_reg[1:0], 3'b000});
    assign calc      = (frame_len_reg == 16'd1) ? 32'h0 : hash_reg;

    // Parse one byte or take a configuration write
    always_comb
    begin
        intercept_next  = intercept_reg;
        sum_type_next   = sum_type_reg;
        phase_next      = phase_reg;
        frame_len_next  = frame_len_reg;
        byte_count_next = byte_count_reg;
        is_summary_next = is_summary_reg;
        hash_next       = hash_reg;
        rx_crc_next     = rx_crc_reg;
        won_next        = won_reg;
        words_next      = words_reg;
        captured_next   = captured_reg;
        push            = 1'b0;
        push_cmd        = '0;

        if (cfg_we)
        begin
            if (cfg_index == lpff_pkg::REG_INTERCEPT)
            begin
                intercept_next  = cfg_data[0];
                phase_next      = PH_LEN_LO;
                frame_len_next  = '0;
                byte_count_next = '0;
                is_summary_next = 1'b0;
                hash_next       = lpff_pkg::FNV_BASIS;
                rx_crc_next     = '0;
            end
            else if (cfg_index == lpff_pkg::REG_SUMMARY_TYPE)
            begin
                sum_type_next = cfg_data;
            end
        end
        else if (accept)
        begin
            if (!intercept_reg)
            begin
                // Transparent: forward the byte
                push        = 1'b1;
                push_cmd.b0 = in_byte;
            end
            else
            begin
                case (phase_reg)
                    PH_LEN_LO:
                    begin
                        frame_len_next = {8'h0, in_byte};
                        phase_next     = PH_LEN_HI;
                    end
                    PH_LEN_HI:
                    begin
                        frame_len_next  = len_full;
                        byte_count_next = '0;
                        rx_crc_next     = '0;
                        is_summary_next = 1'b0;
                        phase_next      = (len_full == 16'd0) ? PH_CHECK : PH_TYPE;
                    end
                    PH_TYPE:
                    begin
                        is_summary_next = (in_byte == sum_type_reg);
                        hash_next       = lpff_pkg::FNV_BASIS;
                        byte_count_next = '0;
                        phase_next      = (frame_len_reg == 16'd1) ? PH_CHECK : PH_PAYLOAD;
                        if (in_byte == sum_type_reg)
                        begin
                            won_next   = '0;
                            words_next = '0;
                        end
                        else
                        begin
                            // Release the held length bytes with the type byte
                            push            = 1'b1;
                            push_cmd.triple = 1'b1;
                            push_cmd.b0     = frame_len_reg[7:0];
                            push_cmd.b1     = frame_len_reg[15:8];
                            push_cmd.b2     = in_byte;
                        end
                    end
                    PH_PAYLOAD:
                    begin
                        if (is_summary_reg)
                        begin
                            hash_next = hash_step;
                            if (byte_count_reg == 16'd0)
                            begin
                                won_next = in_byte;
                            end
                            else if (byte_count_reg < lpff_pkg::SUMMARY_PAYLOAD)
                            begin
                                for (int j = 0; j < 5; j++)
                                begin
                                    if (pos[4:2] == 3'(j))
                                    begin
                                        words_next[j] = words_reg[j]
                                            | (lane_byte << {pos[1:0], 3'b000});
                                    end
                                end
                            end
                        end
                        byte_count_next = bc_inc;
                        if (({1'b0, bc_inc} + 17'd1) >= {1'b0, frame_len_reg})
                        begin
                            byte_count_next = '0;
                            phase_next      = PH_CHECK;
                        end
                        if (!is_summary_reg)
                        begin
                            push        = 1'b1;
                            push_cmd.b0 = in_byte;
                        end
                    end
                    PH_CHECK:
                    begin
                        rx_crc_next = rx_new;
                        if (bc_inc < 16'd4)
                        begin
                            byte_count_next = bc_inc;
                            if (frame_len_reg != 16'd0 && !is_summary_reg)
                            begin
                                push        = 1'b1;
                                push_cmd.b0 = in_byte;
                            end
                        end
                        else
                        begin
                            phase_next      = PH_LEN_LO;
                            byte_count_next = '0;
                            push            = 1'b1;
                            if (frame_len_reg == 16'd0)
                            begin
                                push_cmd.kind = lpff_pkg::KIND_EMPTY;
                            end
                            else if (!is_summary_reg)
                            begin
                                push_cmd.b0 = in_byte;
                            end
                            else if (calc != rx_new)
                            begin
                                push_cmd.kind = lpff_pkg::KIND_BAD_CRC;
                            end
                            else if (frame_len_reg != lpff_pkg::SUMMARY_FRAME_LEN)
                            begin
                                push_cmd.kind = lpff_pkg::KIND_BAD_SIZE;
                            end
                            else
                            begin
                                push_cmd.kind = captured_reg ? lpff_pkg::KIND_DUPLICATE
                                                             : lpff_pkg::KIND_OK;
                                captured_next         = 1'b1;
                                push_cmd.won_flag     = won_reg;
                                push_cmd.own_score    = words_reg[0];
                                push_cmd.own_lines    = words_reg[1];
                                push_cmd.peer_score   = words_reg[2];
                                push_cmd.peer_lines   = words_reg[3];
                                push_cmd.duration_sec = words_reg[4];
                            end
                        end
                    end
                    default:
                    begin
                        phase_next = PH_LEN_LO;
                    end
                endcase
            end
        end
    end

    // Hold parser state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            intercept_reg  <= 1'b0;
            sum_type_reg   <= '0;
            phase_reg      <= PH_LEN_LO;
            frame_len_reg  <= '0;
            byte_count_reg <= '0;
            is_summary_reg <= 1'b0;
            hash_reg       <= lpff_pkg::FNV_BASIS;
            rx_crc_reg     <= '0;
            won_reg        <= '0;
            words_reg      <= '0;
            captured_reg   <= 1'b0;
        end
        else
        begin
            intercept_reg  <= intercept_next;
            sum_type_reg   <= sum_type_next;
            phase_reg      <= phase_next;
            frame_len_reg  <= frame_len_next;
            byte_count_reg <= byte_count_next;
            is_summary_reg <= is_summary_next;
            hash_reg       <= hash_next;
            rx_crc_reg     <= rx_crc_next;
            won_reg        <= won_next;
            words_reg      <= words_next;
            captured_reg   <= captured_next;
        end
    end

    // Once a summary is captured it stays captured
    `LPFF_ASSERT_NXT(a_captured_sticky, captured_reg, captured_reg, "captured flag dropped")

endmodule

### rtl/lpff_queue.sv
// ----------------------------------------------------------------------------
// lpff_queue
// Short request queue between the parser and the output side.
// ----------------------------------------------------------------------------
`include "length_prefixed_frame_filter_top_assert.svh"

module lpff_queue
#(
    parameter int DEPTH = 4
)
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  lpff_pkg::cmd_t push_cmd,
    output logic           full,
    input  logic           pop,
    output logic           head_valid,
    output lpff_pkg::cmd_t head_cmd
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    lpff_pkg::cmd_t mem [DEPTH];
    logic [AW-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]  count_reg, count_next;

    assign full       = (count_reg == CW'(DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_cmd   = mem[rd_ptr_reg];

    // Advance pointers and fill count
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store requests
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_cmd;
        end
    end

    `LPFF_ASSERT_IMP(a_no_overflow, push, !full, "request pushed into full queue")
    `LPFF_ASSERT_IMP(a_no_underflow, pop, head_valid, "request popped from empty queue")

endmodule

### rtl/lpff_back.sv
// ----------------------------------------------------------------------------
// lpff_back
// Output side: expands each request into result items and holds the
// current result in an output register.
// ----------------------------------------------------------------------------
`include "length_prefixed_frame_filter_top_assert.svh"

module lpff_back
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           head_valid,
    input  lpff_pkg::cmd_t head_cmd,
    output logic           pop,
    output logic           out_valid,
    input  logic           out_ready,
    output lpff_pkg::res_t out_res
);

    logic           valid_reg, valid_next;
    logic [1:0]     sub_reg, sub_next;
    lpff_pkg::res_t res_reg, res_next;
    logic           load;
    logic           last_piece;
    logic [7:0]     piece;

    assign load       = head_valid && (!valid_reg || out_ready);
    assign last_piece = !head_cmd.triple || (sub_reg == 2'd2);
    assign pop        = load && last_piece;
    assign out_valid  = valid_reg;
    assign out_res    = res_reg;

    // Pick the byte of a forwarded triple
    always_comb
    begin
        case (sub_reg)
            2'd0:    piece = head_cmd.b0;
            2'd1:    piece = head_cmd.b1;
            default: piece = head_cmd.b2;
        endcase
    end

    // Load the next result or drain the current one
    always_comb
    begin
        valid_next = valid_reg;
        sub_next   = sub_reg;
        res_next   = res_reg;
        if (load)
        begin
            valid_next            = 1'b1;
            sub_next              = last_piece ? 2'd0 : sub_reg + 2'd1;
            res_next.kind         = head_cmd.kind;
            res_next.out_byte     = piece;
            res_next.last         = last_piece;
            res_next.won_flag     = head_cmd.won_flag;
            res_next.own_score    = head_cmd.own_score;
            res_next.own_lines    = head_cmd.own_lines;
            res_next.peer_score   = head_cmd.peer_score;
            res_next.peer_lines   = head_cmd.peer_lines;
            res_next.duration_sec = head_cmd.duration_sec;
        end
        else if (out_ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            sub_reg   <= 2'd0;
        end
        else
        begin
            valid_reg <= valid_next;
            sub_reg   <= sub_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
    end

    // A triple in progress keeps its request at the head
    `LPFF_ASSERT_IMP(a_triple_held, sub_reg != 2'd0, head_valid && head_cmd.triple,
                     "triple expansion lost its request")

endmodule

### rtl/length_prefixed_frame_filter_top.sv
// ----------------------------------------------------------------------------
// length_prefixed_frame_filter_top
// Length-prefixed deframer with FNV-1a summary interception.
//
// Channel  | Direction | Contents
// ---------+-----------+------------------------------------------------------
// s_axis   | in        | tdata[7:0] stream byte
// m_axis   | out       | tuser kind, tlast last, tdata decoded result
// cfg      | in        | we / index / data register writes, no read-back
//
// One byte is accepted per cycle while the queue is not full and no register
// write is taken; each byte yields zero to three results, and results leave at
// one per cycle from the output register while m_axis_tready is high. A forwarded
// type byte yields three results; the request queue (QUEUE_DEPTH entries) absorbs
// that burst and output stalls. Results pass the queue, then the output register.
// Reset is asynchronous and active low; no clearing pass is needed.
// ----------------------------------------------------------------------------
module length_prefixed_frame_filter_top
#(
    parameter int QUEUE_DEPTH = 4
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    input  logic [7:0]                     s_axis_tdata,   // in_byte
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    // out_byte, won_flag, own_score, own_lines, peer_score, peer_lines, duration_sec
    output logic [175:0]                   m_axis_tdata,
    output logic [2:0]                     m_axis_tuser,   // kind
    output logic                           m_axis_tlast,
    input  logic                           cfg_we,
    input  logic [lpff_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [7:0]                     cfg_data
);

    lpff_pkg::cmd_t push_cmd;
    lpff_pkg::cmd_t head_cmd;
    lpff_pkg::res_t res;
    logic           push;
    logic           q_full;
    logic           pop;
    logic           head_valid;

    lpff_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_byte   (s_axis_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .q_full    (q_full),
        .push      (push),
        .push_cmd  (push_cmd)
    );

    lpff_queue #(.DEPTH(QUEUE_DEPTH)) u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_cmd   (push_cmd),
        .full       (q_full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_cmd   (head_cmd)
    );

    lpff_back u_back
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head_cmd   (head_cmd),
        .pop        (pop),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .out_res    (res)
    );

    // Pack the result
    assign m_axis_tdata = {res.duration_sec, res.peer_lines, res.peer_score,
                           res.own_lines, res.own_score, res.won_flag, res.out_byte};
    assign m_axis_tuser = res.kind;
    assign m_axis_tlast = res.last;

endmodule
